// File: sv/mbss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mbss_pkg;

	localparam int MAX_SIG_LEN = 8;
	localparam int NUM_SIGS    = 2;
	localparam int LEN_W       = $clog2(MAX_SIG_LEN + 1);
	localparam int POS_W       = $clog2(MAX_SIG_LEN);
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int ADDR_W      = 64;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIG0_BYTES    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIG0_CARE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIG0_LENGTH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SIG1_BYTES    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SIG1_CARE     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SIG1_LENGTH   = 3'd7;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage
`default_nettype wire

// File: sv/mbss_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module mbss_cell (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  mbss_pkg::cell_ctl_t                      ctl,
	input  wire logic [7:0]                          din,
	input  wire logic [mbss_pkg::NUM_SIGS-1:0][7:0]  sig_byte,
	input  wire logic [mbss_pkg::NUM_SIGS-1:0]       care,
	input  wire logic [mbss_pkg::NUM_SIGS-1:0]       live,
	output logic      [7:0]                          dout,
	output logic      [mbss_pkg::NUM_SIGS-1:0]       ok
);
	import mbss_pkg::*;

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'h00;
		end else if (ctl.clear) begin
			byte_q <= 8'h00;
		end else if (ctl.shift) begin
			byte_q <= din;
		end
	end

	// a byte past the signature length or a don't-care byte always passes
	always_comb begin
		for (int s = 0; s < NUM_SIGS; s++) begin
			ok[s] = !live[s] || !care[s] || (byte_q == sig_byte[s]);
		end
	end

	assign dout = byte_q;

endmodule
`default_nettype wire

// File: sv/masked_byte_signature_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// The word that completes a window sets eval_q; the output register then takes the result.
// Throughput: one input word per cycle while no final word is flushing, unless a result
// waits on m_tready. A final word starts a flush through the cell row, one step per cell
// (one step per cycle, stalled by m_tready); input is held off until the flush ends.
// Reset (arst_n low): window and byte count cleared, registers to their defaults.
module masked_byte_signature_scanner (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wen,
	input  wire logic [mbss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [mbss_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [7:0]                         s_tdata,  // [7:0] data_byte
	input  wire logic                               s_tlast,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic      [mbss_pkg::ADDR_W-1:0]        m_tdata,  // [63:0] start_address
	output logic      [1:0]                         m_tuser,  // [0] matched, [1] signature_index
	output logic                                    m_tlast
);
	import mbss_pkg::*;

	logic [1:0]                      count_q;
	logic [ADDR_W-1:0]               base_q;
	logic [NUM_SIGS-1:0][63:0]       sig_bytes_q;
	logic [NUM_SIGS-1:0][7:0]        sig_care_q;
	logic [NUM_SIGS-1:0][3:0]        sig_len_q;

	logic [63:0]                     seen_q;
	logic [ADDR_W-1:0]               posn_q;
	logic                            eval_q;
	logic                            flush_q;
	logic [POS_W-1:0]                fk_q;
	logic [LEN_W-1:0]                held_q;

	logic                            out_valid_q;
	logic [ADDR_W-1:0]               addr_q;
	logic [1:0]                      user_q;
	logic                            last_q;

	logic                            can_load;
	logic                            accept;
	logic                            fstep;
	logic                            fdone;
	logic                            emit_k;
	logic                            load;
	logic [63:0]                     seen_nxt;
	logic                            full_nxt;
	logic [LEN_W-1:0]                avail;
	logic [7:0]                      in_byte;
	cell_ctl_t                       ctl;

	logic [MAX_SIG_LEN-1:0][7:0]          win;
	logic [MAX_SIG_LEN-1:0][NUM_SIGS-1:0] ok_mat;
	logic [NUM_SIGS-1:0][LEN_W-1:0]       len_eff;
	logic [NUM_SIGS-1:0]                  hit;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			base_q      <= '0;
			sig_bytes_q <= '0;
			sig_care_q  <= '1;
			for (int s = 0; s < NUM_SIGS; s++) begin
				sig_len_q[s] <= 4'(MAX_SIG_LEN);
			end
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_PATTERN_COUNT: count_q        <= cfg_wdata[1:0];
				REG_BASE_ADDRESS:  base_q         <= cfg_wdata;
				REG_SIG0_BYTES:    sig_bytes_q[0] <= cfg_wdata;
				REG_SIG0_CARE:     sig_care_q[0]  <= cfg_wdata[7:0];
				REG_SIG0_LENGTH:   sig_len_q[0]   <= cfg_wdata[3:0];
				REG_SIG1_BYTES:    sig_bytes_q[1] <= cfg_wdata;
				REG_SIG1_CARE:     sig_care_q[1]  <= cfg_wdata[7:0];
				REG_SIG1_LENGTH:   sig_len_q[1]   <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// handshake and sequencing
	assign can_load = !out_valid_q || m_tready;
	assign s_tready = !flush_q && (!eval_q || can_load);
	assign accept   = s_tvalid && s_tready;
	assign fstep    = flush_q && can_load;
	assign fdone    = fstep && (fk_q == POS_W'(MAX_SIG_LEN - 1));
	assign seen_nxt = seen_q + 64'd1;
	assign full_nxt = seen_nxt >= 64'(MAX_SIG_LEN);
	assign avail    = flush_q ? LEN_W'(MAX_SIG_LEN) - LEN_W'(fk_q) : LEN_W'(MAX_SIG_LEN);
	assign emit_k   = avail <= held_q;
	assign load     = can_load && (eval_q || (flush_q && emit_k));
	assign in_byte  = accept ? s_tdata : 8'h00;
	assign ctl.shift = accept || fstep;
	assign ctl.clear = fdone;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			posn_q  <= ADDR_W'(0) - ADDR_W'(MAX_SIG_LEN);
			eval_q  <= 1'b0;
			flush_q <= 1'b0;
			fk_q    <= '0;
			held_q  <= '0;
		end else begin
			eval_q <= accept ? (!s_tlast && full_nxt) : (eval_q && !can_load);
			if (accept) begin
				seen_q <= seen_nxt;
				posn_q <= posn_q + ADDR_W'(1);
				if (s_tlast) begin
					flush_q <= 1'b1;
					fk_q    <= '0;
					held_q  <= full_nxt ? LEN_W'(MAX_SIG_LEN) : LEN_W'(seen_nxt[POS_W-1:0]);
				end
			end else if (fdone) begin
				seen_q  <= '0;
				posn_q  <= ADDR_W'(0) - ADDR_W'(MAX_SIG_LEN);
				flush_q <= 1'b0;
				fk_q    <= '0;
			end else if (fstep) begin
				posn_q <= posn_q + ADDR_W'(1);
				fk_q   <= fk_q + POS_W'(1);
			end
		end
	end

	// cell row
	always_comb begin
		for (int s = 0; s < NUM_SIGS; s++) begin
			len_eff[s] = (sig_len_q[s] > 4'(MAX_SIG_LEN)) ? LEN_W'(MAX_SIG_LEN)
				: LEN_W'(sig_len_q[s]);
		end
	end

	for (genvar j = 0; j < MAX_SIG_LEN; j++) begin : g_cell
		logic [7:0]                     din;
		logic [NUM_SIGS-1:0][7:0]       sb;
		logic [NUM_SIGS-1:0]            cr;
		logic [NUM_SIGS-1:0]            lv;

		if (j == MAX_SIG_LEN - 1) begin : g_head
			assign din = in_byte;
		end else begin : g_body
			assign din = win[j+1];
		end

		always_comb begin
			for (int s = 0; s < NUM_SIGS; s++) begin
				sb[s] = sig_bytes_q[s][8*j +: 8];
				cr[s] = sig_care_q[s][j];
				lv[s] = LEN_W'(j) < len_eff[s];
			end
		end

		mbss_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.din      (din),
			.sig_byte (sb),
			.care     (cr),
			.live     (lv),
			.dout     (win[j]),
			.ok       (ok_mat[j])
		);
	end

	always_comb begin
		for (int s = 0; s < NUM_SIGS; s++) begin
			hit[s] = (int'(count_q) > s) && (len_eff[s] <= avail);
			for (int j = 0; j < MAX_SIG_LEN; j++) begin
				hit[s] = hit[s] && ok_mat[j][s];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			addr_q    <= base_q + posn_q;
			user_q[0] <= |hit;
			user_q[1] <= hit[1];
			last_q    <= flush_q && (fk_q == POS_W'(MAX_SIG_LEN - 1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = addr_q;
	assign m_tuser  = user_q;
	assign m_tlast  = last_q;

	a_no_input_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> !s_tready)
		else $error("input taken during flush");

	a_eval_flush_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(eval_q && flush_q))
		else $error("pending compare overlaps flush");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(eval_q || flush_q))
		else $error("result without a pending compare");

endmodule
`default_nettype wire
